// ----- hw/rtl/cps_pkg.sv -----
// ----------------------------------------------------------------------------
// cps_pkg
// shared types, constants and helper functions of the corridor pair steering
// ----------------------------------------------------------------------------
package cps_pkg;

   localparam int MAX_SEGMENTS = 64;
   localparam int SEG_W        = $clog2(MAX_SEGMENTS);
   localparam int KEEP_W       = $clog2(MAX_SEGMENTS + 1);
   localparam int PADDR_W      = 5;
   localparam int ENTRY_W      = 48;

   localparam logic [2:0] REG_SLOPE_TOL = 3'd0;
   localparam logic [2:0] REG_MAX_SD    = 3'd1;
   localparam logic [2:0] REG_MAX_PD    = 3'd2;
   localparam logic [2:0] REG_LOOKAHEAD = 3'd3;
   localparam logic [2:0] REG_WHEELBASE = 3'd4;
   localparam logic [2:0] REG_GAIN      = 3'd5;

   localparam logic [7:0] PAIR_SPEED = 8'd200;

   typedef enum logic [1:0] {
      STAT_PAIR     = 2'd0,
      STAT_FEW_SEG  = 2'd1,
      STAT_FEW_KEPT = 2'd2,
      STAT_NO_PAIR  = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DIV,
      ST_KEEP,
      ST_LAST,
      ST_RD_N,
      ST_N_DATA,
      ST_N_SIGN,
      ST_SCAN_RD,
      ST_SCAN_A,
      ST_SCAN_B,
      ST_SCAN_C,
      ST_PP_RD,
      ST_PP_MUL,
      ST_PP_TY,
      ST_MUL_WY,
      ST_MUL_LL,
      ST_MUL_TT,
      ST_CORDIC,
      ST_GAIN,
      ST_TURN,
      ST_RESULT
   } state_type;

   function automatic logic signed [18:0] cordic_atan(input logic [3:0] i);
      logic signed [18:0] v;
      case (i)
         4'd0:    v = 19'sd51472;
         4'd1:    v = 19'sd30385;
         4'd2:    v = 19'sd16055;
         4'd3:    v = 19'sd8150;
         4'd4:    v = 19'sd4091;
         4'd5:    v = 19'sd2047;
         4'd6:    v = 19'sd1024;
         4'd7:    v = 19'sd512;
         4'd8:    v = 19'sd256;
         4'd9:    v = 19'sd128;
         4'd10:   v = 19'sd64;
         4'd11:   v = 19'sd32;
         4'd12:   v = 19'sd16;
         4'd13:   v = 19'sd8;
         4'd14:   v = 19'sd4;
         default: v = 19'sd2;
      endcase
      return v;
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
      logic signed [15:0] r;
      if (v > 40'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -40'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

// ----- hw/rtl/cps_if.sv -----
// ----------------------------------------------------------------------------
// cps channel interfaces
// segment request channel and steering response channel
// ----------------------------------------------------------------------------
interface cps_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] start_x;
   logic signed [15:0] start_y;
   logic signed [15:0] end_x;
   logic signed [15:0] end_y;
   logic               last_segment;

   modport source (output valid, start_x, start_y, end_x, end_y, last_segment,
                   input ready);
   modport sink   (input valid, start_x, start_y, end_x, end_y, last_segment,
                   output ready);
endinterface

interface cps_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic signed [15:0] turn_rate;
   logic [7:0]         forward_speed;
   logic signed [15:0] target_y;

   modport source (output valid, status, turn_rate, forward_speed, target_y,
                   input ready);
   modport sink   (input valid, status, turn_rate, forward_speed, target_y,
                   output ready);
endinterface

// ----- hw/rtl/corridor_pair_steering.sv -----
// ----------------------------------------------------------------------------
// corridor_pair_steering
// steering from a pair of corridor walls found in one scan of line segments
// ----------------------------------------------------------------------------
// req carries one line segment per transaction, the final one of a scan
// flagged by last_segment. rsp carries one steering transaction per scan,
// issued after the last segment. the apb port sets thresholds and geometry
// and the user must write it only while the block is idle; the block does
// not enforce this. a dropped or vertical segment is taken in ST_IDLE alone;
// any other one runs the slope divider, four quotient bits a cycle in ST_DIV,
// then ST_KEEP stores it if kept. one item is worked on at a time.
// after the last segment the pairing pass reads the segment memory one entry
// at a time through ST_SCAN_RD, ST_SCAN_A, ST_SCAN_B and ST_SCAN_C per kept
// segment, then pure-pursuit math with cordic before the response is loaded.
// the response sits in an output register; a stalled receiver holds it and
// the next scan's segments are still taken, only a second response waits.
// reset clears the scan counters, the response valid and the registers to
// their defaults; the segment memory needs no clearing.
// ----------------------------------------------------------------------------
module corridor_pair_steering (
   input  logic                         clock,
   input  logic                         reset,
   cps_req_if.sink                      req,
   cps_rsp_if.source                    rsp,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [cps_pkg::PADDR_W-1:0]  paddr,
   input  logic [31:0]                  pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready
);
   import cps_pkg::*;

   state_type state_ff, state_in;

   logic [15:0] slope_tol_ff, max_sd_ff, max_pd_ff, gain_ff;
   logic [14:0] look_ff, wheel_ff;

   logic signed [15:0] sx_ff, sy_ff, ex_ff, ey_ff;
   logic signed [15:0] sx_in, sy_in, ex_in, ey_in;
   logic               last_ff, last_in;

   logic [6:0]        raw_cnt_ff, raw_cnt_in;
   logic [KEEP_W-1:0] kept_ff, kept_in;
   logic [SEG_W-1:0]  near_idx_ff, near_idx_in;
   logic [31:0]       near_rsq_ff, near_rsq_in;

   logic [16:0] rem_ff, rem_in, adx_ff, adx_in;
   logic [15:0] num_ff, num_in, q_ff, q_in;
   logic        sat_ff, sat_in, neg_ff, neg_in;
   logic [3:0]  step_ff, step_in;
   logic [31:0] ds_ff, ds_in, de_ff, de_in;

   logic [ENTRY_W-1:0] mem [MAX_SEGMENTS];
   logic [ENTRY_W-1:0] rd_data_ff, wr_data;
   logic [SEG_W-1:0]   rd_addr, wr_addr;
   logic               wr_en;

   logic signed [15:0] x1_ff, x1_in, y1_ff, y1_in, s1_ff, s1_in, yi_ff, yi_in;
   logic               b1p_ff, b1p_in, b1n_ff, b1n_in;
   logic [KEEP_W-1:0]  idx_ff, idx_in;
   logic [SEG_W-1:0]   best_ff, best_in;
   logic               found_ff, found_in, sd_ok_ff, sd_ok_in, skip_ff, skip_in;
   logic [33:0]        min_d2_ff, min_d2_in;
   logic signed [16:0] ddx_ff, ddx_in, ddy_ff, ddy_in, ysum_ff, ysum_in;
   logic [31:0]        dxsq_ff, dxsq_in;
   logic signed [36:0] prod_ff, prod_in;
   logic signed [15:0] ty_ff, ty_in, turn_ff, turn_in;
   logic signed [35:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [18:0] z_ff, z_in;
   status_type         res_stat_ff, res_stat_in;

   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_stat_ff;
   logic signed [15:0] rsp_turn_ff, rsp_ty_ff;
   logic               load;

   logic req_fire, cfg_wr;
   logic signed [16:0] in_dx, in_dy;
   logic [16:0]        in_adx, in_ady;
   logic               in_drop;
   logic               div_done, cordic_done;

   logic signed [15:0] rd_x, rd_y, rd_s;
   logic signed [15:0] sq_u, sq_v;
   logic [31:0]        sq_sum;
   logic [15:0]        slope_mag, slope_val;
   logic               keep_ok;
   logic signed [32:0] term;
   logic [16:0]        sd_abs;
   logic signed [16:0] sd_raw;
   logic [33:0]        d2;
   logic signed [37:0] ty_num;
   logic signed [18:0] pp_a;
   logic signed [16:0] pp_ssum;
   logic signed [36:0] turn_num;

   assign pready   = 1'b1;
   assign cfg_wr   = psel & penable & pwrite;
   assign req.ready = (state_ff == ST_IDLE);
   assign req_fire = req.valid & req.ready;

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.status        = rsp_stat_ff;
   assign rsp.turn_rate     = rsp_turn_ff;
   assign rsp.target_y      = rsp_ty_ff;
   assign rsp.forward_speed = (rsp_stat_ff == STAT_PAIR) ? PAIR_SPEED : 8'd0;

   assign load = (state_ff == ST_RESULT) & (~rsp_valid_ff | rsp.ready);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         slope_tol_ff <= 16'd256;
         max_sd_ff    <= 16'd128;
         max_pd_ff    <= 16'd3072;
         look_ff      <= 15'd1024;
         wheel_ff     <= 15'd256;
         gain_ff      <= 16'd256;
      end else if (cfg_wr) begin
         unique case (paddr[4:2])
            REG_SLOPE_TOL: slope_tol_ff <= pwdata[15:0];
            REG_MAX_SD:    max_sd_ff    <= pwdata[15:0];
            REG_MAX_PD:    max_pd_ff    <= pwdata[15:0];
            REG_LOOKAHEAD: look_ff      <= pwdata[14:0];
            REG_WHEELBASE: wheel_ff     <= pwdata[14:0];
            REG_GAIN:      gain_ff      <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[4:2])
         REG_SLOPE_TOL: prdata = {16'd0, slope_tol_ff};
         REG_MAX_SD:    prdata = {16'd0, max_sd_ff};
         REG_MAX_PD:    prdata = {16'd0, max_pd_ff};
         REG_LOOKAHEAD: prdata = {17'd0, look_ff};
         REG_WHEELBASE: prdata = {17'd0, wheel_ff};
         REG_GAIN:      prdata = {16'd0, gain_ff};
         default:       prdata = 32'd0;
      endcase
   end

   // segment memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_x = rd_data_ff[15:0];
   assign rd_y = rd_data_ff[31:16];
   assign rd_s = rd_data_ff[47:32];

   // incoming segment decode
   assign in_dx  = 17'(req.end_x) - 17'(req.start_x);
   assign in_dy  = 17'(req.end_y) - 17'(req.start_y);
   assign in_adx = in_dx[16] ? 17'(-in_dx) : 17'(in_dx);
   assign in_ady = in_dy[16] ? 17'(-in_dy) : 17'(in_dy);
   assign in_drop = (req.start_x[15] & req.end_x[15]) | (in_dx == 17'sd0);

   assign div_done    = (step_ff == 4'd3);
   assign cordic_done = (step_ff == 4'd15);

   // slope and nearest point
   assign sq_u   = step_ff[0] ? ex_ff : sx_ff;
   assign sq_v   = step_ff[0] ? ey_ff : sy_ff;
   assign sq_sum = 32'(sq_u * sq_u) + 32'(sq_v * sq_v);

   always_comb begin
      if (sat_ff) begin
         slope_mag = neg_ff ? 16'h8000 : 16'h7fff;
         slope_val = neg_ff ? 16'h8000 : 16'h7fff;
      end else begin
         slope_mag = q_ff;
         slope_val = neg_ff ? 16'(-q_ff) : q_ff;
      end
   end
   assign keep_ok = (slope_mag < slope_tol_ff) & (kept_ff < KEEP_W'(MAX_SEGMENTS));

   // pairing arithmetic
   assign term   = (33'(yi_ff) <<< 8) - 33'(prod_ff);
   assign sd_raw = 17'(rd_s) - 17'(s1_ff);
   assign sd_abs = sd_raw[16] ? 17'(-sd_raw) : 17'(sd_raw);
   assign d2     = 34'(dxsq_ff) + 34'(ddy_ff * ddy_ff);

   assign pp_ssum  = 17'(s1_ff) + 17'(rd_s);
   assign pp_a     = 19'({1'b0, look_ff, 1'b0}) - 19'(x1_ff) - 19'(rd_x);
   assign ty_num   = 38'(prod_ff) + (38'(ysum_ff) <<< 9) + 38'sd512;
   assign turn_num = prod_ff + 37'sd2048;

   always_comb begin
      logic [17:0] r18;
      logic [16:0] r;
      logic [15:0] n, q;
      logic signed [35:0] xs, ys;

      sx_in = sx_ff; sy_in = sy_ff; ex_in = ex_ff; ey_in = ey_ff; last_in = last_ff;
      raw_cnt_in = raw_cnt_ff; kept_in = kept_ff;
      near_idx_in = near_idx_ff; near_rsq_in = near_rsq_ff;
      rem_in = rem_ff; adx_in = adx_ff; num_in = num_ff; q_in = q_ff;
      sat_in = sat_ff; neg_in = neg_ff; step_in = step_ff;
      ds_in = ds_ff; de_in = de_ff;
      x1_in = x1_ff; y1_in = y1_ff; s1_in = s1_ff; yi_in = yi_ff;
      b1p_in = b1p_ff; b1n_in = b1n_ff;
      idx_in = idx_ff; best_in = best_ff; found_in = found_ff;
      sd_ok_in = sd_ok_ff; skip_in = skip_ff; min_d2_in = min_d2_ff;
      ddx_in = ddx_ff; ddy_in = ddy_ff; ysum_in = ysum_ff; dxsq_in = dxsq_ff;
      prod_in = prod_ff; ty_in = ty_ff; turn_in = turn_ff;
      cx_in = cx_ff; cy_in = cy_ff; z_in = z_ff; res_stat_in = res_stat_ff;
      rd_addr = idx_ff[SEG_W-1:0];
      wr_en = 1'b0;
      wr_addr = kept_ff[SEG_W-1:0];
      wr_data = '0;
      r18 = '0; r = rem_ff; n = num_ff; q = q_ff;
      xs = cx_ff >>> step_ff;
      ys = cy_ff >>> step_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               sx_in = req.start_x; sy_in = req.start_y;
               ex_in = req.end_x;   ey_in = req.end_y;
               last_in = req.last_segment;
               if (raw_cnt_ff != 7'd127) begin
                  raw_cnt_in = raw_cnt_ff + 7'd1;
               end
               adx_in = in_adx;
               sat_in = ({7'd0, in_ady} >= {in_adx, 7'd0});
               neg_in = in_dx[16] ^ in_dy[16];
               rem_in = {8'd0, in_ady[16:8]};
               num_in = {in_ady[7:0], 8'd0};
               q_in = '0;
               step_in = '0;
            end
         end
         ST_DIV: begin
            for (int k = 0; k < 4; k++) begin
               r18 = {r, n[15]};
               n = {n[14:0], 1'b0};
               if (r18 >= {1'b0, adx_ff}) begin
                  r = 17'(r18 - {1'b0, adx_ff});
                  q = {q[14:0], 1'b1};
               end else begin
                  r = r18[16:0];
                  q = {q[14:0], 1'b0};
               end
            end
            rem_in = r; num_in = n; q_in = q;
            if (step_ff == 4'd0) begin
               ds_in = sq_sum;
            end
            if (step_ff == 4'd1) begin
               de_in = sq_sum;
            end
            step_in = div_done ? 4'd0 : step_ff + 4'd1;
         end
         ST_KEEP: begin
            if (keep_ok) begin
               wr_en = 1'b1;
               if (ds_ff < de_ff) begin
                  wr_data = {slope_val, sy_ff, sx_ff};
               end else begin
                  wr_data = {slope_val, ey_ff, ex_ff};
               end
               if (((ds_ff < de_ff) ? ds_ff : de_ff) < near_rsq_ff) begin
                  near_rsq_in = (ds_ff < de_ff) ? ds_ff : de_ff;
                  near_idx_in = kept_ff[SEG_W-1:0];
               end
               kept_in = kept_ff + KEEP_W'(1);
            end
         end
         ST_LAST: begin
            ty_in = '0;
            turn_in = '0;
            if (raw_cnt_ff < 7'd2) begin
               res_stat_in = STAT_FEW_SEG;
            end else if (kept_ff < KEEP_W'(2)) begin
               res_stat_in = STAT_FEW_KEPT;
            end
         end
         ST_RD_N: begin
            rd_addr = near_idx_ff;
         end
         ST_N_DATA: begin
            x1_in = rd_x; y1_in = rd_y; s1_in = rd_s; yi_in = rd_y;
            prod_in = 37'(rd_s * rd_x);
         end
         ST_N_SIGN: begin
            b1p_in = ~term[32] & (term != 33'sd0);
            b1n_in = term[32];
            idx_in = '0;
            found_in = 1'b0;
            min_d2_in = 34'(32'(max_pd_ff * max_pd_ff));
         end
         ST_SCAN_RD: begin
            if (idx_ff != kept_ff && idx_ff[SEG_W-1:0] == near_idx_ff) begin
               idx_in = idx_ff + KEEP_W'(1);
            end
            if (idx_ff == kept_ff && !found_ff) begin
               res_stat_in = STAT_NO_PAIR;
            end
            if (idx_ff == kept_ff) begin
               rd_addr = best_ff;
            end
         end
         ST_SCAN_A: begin
            yi_in = rd_y;
            sd_ok_in = (sd_abs < {1'b0, max_sd_ff});
            prod_in = 37'(rd_s * rd_x);
            ddx_in = 17'(rd_x) - 17'(x1_ff);
            ddy_in = 17'(rd_y) - 17'(y1_ff);
         end
         ST_SCAN_B: begin
            skip_in = ~sd_ok_ff | (b1p_ff & ~term[32] & (term != 33'sd0))
                      | (b1n_ff & term[32]);
            dxsq_in = 32'(ddx_ff * ddx_ff);
         end
         ST_SCAN_C: begin
            if (!skip_ff && d2 < min_d2_ff) begin
               min_d2_in = d2;
               best_in = idx_ff[SEG_W-1:0];
               found_in = 1'b1;
            end
            idx_in = idx_ff + KEEP_W'(1);
         end
         ST_PP_RD: begin
            rd_addr = best_ff;
         end
         ST_PP_MUL: begin
            prod_in = 37'(pp_ssum * pp_a);
            ysum_in = 17'(y1_ff) + 17'(rd_y);
         end
         ST_PP_TY: begin
            ty_in = sat16(40'(ty_num >>> 10));
            res_stat_in = STAT_PAIR;
         end
         ST_MUL_WY: begin
            cy_in = 36'($signed({1'b0, wheel_ff}) * ty_ff) <<< 1;
         end
         ST_MUL_LL: begin
            cx_in = 36'({1'b0, look_ff} * {1'b0, look_ff});
         end
         ST_MUL_TT: begin
            cx_in = cx_ff + 36'(ty_ff * ty_ff);
            z_in = '0;
            step_in = '0;
         end
         ST_CORDIC: begin
            if (!cy_ff[35]) begin
               cx_in = cx_ff + ys;
               cy_in = cy_ff - xs;
               z_in = z_ff + cordic_atan(step_ff);
            end else begin
               cx_in = cx_ff - ys;
               cy_in = cy_ff + xs;
               z_in = z_ff - cordic_atan(step_ff);
            end
            step_in = step_ff + 4'd1;
         end
         ST_GAIN: begin
            prod_in = 37'($signed({1'b0, gain_ff}) * z_ff);
         end
         ST_TURN: begin
            turn_in = sat16(40'(turn_num >>> 12));
         end
         ST_RESULT: begin
            if (load) begin
               raw_cnt_in = '0;
               kept_in = '0;
               near_idx_in = '0;
               near_rsq_in = '1;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (!in_drop) begin
                  state_in = ST_DIV;
               end else if (req.last_segment) begin
                  state_in = ST_LAST;
               end
            end
         end
         ST_DIV:     state_in = div_done ? ST_KEEP : ST_DIV;
         ST_KEEP:    state_in = last_ff ? ST_LAST : ST_IDLE;
         ST_LAST: begin
            if (raw_cnt_ff < 7'd2 || kept_ff < KEEP_W'(2)) begin
               state_in = ST_RESULT;
            end else begin
               state_in = ST_RD_N;
            end
         end
         ST_RD_N:    state_in = ST_N_DATA;
         ST_N_DATA:  state_in = ST_N_SIGN;
         ST_N_SIGN:  state_in = ST_SCAN_RD;
         ST_SCAN_RD: begin
            if (idx_ff == kept_ff) begin
               state_in = found_ff ? ST_PP_MUL : ST_RESULT;
            end else if (idx_ff[SEG_W-1:0] != near_idx_ff) begin
               state_in = ST_SCAN_A;
            end
         end
         ST_SCAN_A:  state_in = ST_SCAN_B;
         ST_SCAN_B:  state_in = ST_SCAN_C;
         ST_SCAN_C:  state_in = ST_SCAN_RD;
         ST_PP_RD:   state_in = ST_PP_MUL;
         ST_PP_MUL:  state_in = ST_PP_TY;
         ST_PP_TY:   state_in = ST_MUL_WY;
         ST_MUL_WY:  state_in = ST_MUL_LL;
         ST_MUL_LL:  state_in = ST_MUL_TT;
         ST_MUL_TT:  state_in = (cy_ff == 36'sd0) ? ST_GAIN : ST_CORDIC;
         ST_CORDIC:  state_in = cordic_done ? ST_GAIN : ST_CORDIC;
         ST_GAIN:    state_in = ST_TURN;
         ST_TURN:    state_in = ST_RESULT;
         ST_RESULT:  state_in = load ? ST_IDLE : ST_RESULT;
         default:    state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = load | (rsp_valid_ff & ~rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         raw_cnt_ff   <= '0;
         kept_ff      <= '0;
         near_idx_ff  <= '0;
         near_rsq_ff  <= '1;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         raw_cnt_ff   <= raw_cnt_in;
         kept_ff      <= kept_in;
         near_idx_ff  <= near_idx_in;
         near_rsq_ff  <= near_rsq_in;
      end
   end

   always_ff @(posedge clock) begin
      sx_ff <= sx_in; sy_ff <= sy_in; ex_ff <= ex_in; ey_ff <= ey_in;
      last_ff <= last_in;
      rem_ff <= rem_in; adx_ff <= adx_in; num_ff <= num_in; q_ff <= q_in;
      sat_ff <= sat_in; neg_ff <= neg_in; step_ff <= step_in;
      ds_ff <= ds_in; de_ff <= de_in;
      x1_ff <= x1_in; y1_ff <= y1_in; s1_ff <= s1_in; yi_ff <= yi_in;
      b1p_ff <= b1p_in; b1n_ff <= b1n_in;
      idx_ff <= idx_in; best_ff <= best_in; found_ff <= found_in;
      sd_ok_ff <= sd_ok_in; skip_ff <= skip_in; min_d2_ff <= min_d2_in;
      ddx_ff <= ddx_in; ddy_ff <= ddy_in; ysum_ff <= ysum_in; dxsq_ff <= dxsq_in;
      prod_ff <= prod_in; ty_ff <= ty_in; turn_ff <= turn_in;
      cx_ff <= cx_in; cy_ff <= cy_in; z_ff <= z_in; res_stat_ff <= res_stat_in;
      if (load) begin
         rsp_stat_ff <= res_stat_ff;
         rsp_turn_ff <= turn_ff;
         rsp_ty_ff   <= ty_ff;
      end
   end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// corridor pair steering testbench
// drives scans of line segments with random gaps and response stalls,
// predicts each steering transaction in a local model of the block and
// compares every field; registers are changed between scans over apb
// ----------------------------------------------------------------------------
module testbench;
   import cps_pkg::*;

   localparam int WATCHDOG_LIMIT = 6000;
   localparam int STORE_DEPTH    = MAX_SEGMENTS;

   typedef struct {
      status_type         status;
      logic signed [15:0] turn_rate;
      logic [7:0]         forward_speed;
      logic signed [15:0] target_y;
   } steer_cmd_type;

   logic        clock;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [PADDR_W-1:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   cps_req_if req_if ();
   cps_rsp_if rsp_if ();

   corridor_pair_steering u_dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_if),
      .rsp     (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // local copy of registers and scan state
   longint slope_tol, max_sd, max_pd, lookahead, wheelbase_len, gain;
   longint near_x [STORE_DEPTH];
   longint near_y [STORE_DEPTH];
   longint slope_mem [STORE_DEPTH];
   int     raw_count, kept_count, nearest_idx;
   longint nearest_rsq;

   steer_cmd_type expected_cmds [$];
   int errors;
   int items_sent;
   bit req_idling;
   bit rsp_idling;
   int rsp_hold;
   int idle_cycles;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic longint clip16(input longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic longint sign_of(input longint v);
      return (v > 0) - (v < 0);
   endfunction

   function automatic longint cordic_angle(input longint y0, input longint x0);
      longint x, y, z, xs, ys;
      x = x0;
      y = y0;
      z = 0;
      if (y == 0) return 0;
      for (int i = 0; i < 16; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys; y = y - xs; z = z + longint'(cordic_atan(i[3:0]));
         end else begin
            x = x - ys; y = y + xs; z = z - longint'(cordic_atan(i[3:0]));
         end
      end
      return z;
   endfunction

   function automatic void clear_scan();
      raw_count   = 0;
      kept_count  = 0;
      nearest_idx = 0;
      nearest_rsq = 64'hFFFF_FFFF;
   endfunction

   // updates scan state with one segment; on the last one queues a command
   function automatic void predict_steering(input longint sx, input longint sy,
                                            input longint ex, input longint ey,
                                            input bit last);
      longint dx, dy, slope, mag, ds, de, r;
      longint x1, y1, s1, b1, min_d2, sd, ddx, ddy, d2, x2, y2, s2, num, tyv, ang;
      int best;
      bit found;
      steer_cmd_type cmd;
      if (raw_count < 127) raw_count++;
      if (!(sx < 0 && ex < 0) && ex != sx) begin
         dx = ex - sx;
         dy = ey - sy;
         slope = clip16((dy * 256) / dx);
         mag = slope < 0 ? -slope : slope;
         if (mag < slope_tol && kept_count < STORE_DEPTH) begin
            ds = sx * sx + sy * sy;
            de = ex * ex + ey * ey;
            if (ds < de) begin
               near_x[kept_count] = sx; near_y[kept_count] = sy; r = ds;
            end else begin
               near_x[kept_count] = ex; near_y[kept_count] = ey; r = de;
            end
            slope_mem[kept_count] = slope;
            if (r < nearest_rsq) begin
               nearest_rsq = r;
               nearest_idx = kept_count;
            end
            kept_count++;
         end
      end
      if (!last) return;
      cmd = '{STAT_PAIR, 16'sd0, 8'd0, 16'sd0};
      if (raw_count < 2) begin
         cmd.status = STAT_FEW_SEG;
      end else if (kept_count < 2) begin
         cmd.status = STAT_FEW_KEPT;
      end else begin
         x1 = near_x[nearest_idx];
         y1 = near_y[nearest_idx];
         s1 = slope_mem[nearest_idx];
         b1 = sign_of(y1 * 256 - s1 * x1);
         min_d2 = max_pd * max_pd;
         found = 0;
         best = 0;
         for (int i = 0; i < kept_count; i++) begin
            if (i == nearest_idx) continue;
            sd = slope_mem[i] - s1;
            if (sd < 0) sd = -sd;
            if (sd >= max_sd) continue;
            if (b1 * sign_of(near_y[i] * 256 - slope_mem[i] * near_x[i]) > 0) continue;
            ddx = near_x[i] - x1;
            ddy = near_y[i] - y1;
            d2 = ddx * ddx + ddy * ddy;
            if (d2 < min_d2) begin
               min_d2 = d2;
               best = i;
               found = 1;
            end
         end
         if (!found) begin
            cmd.status = STAT_NO_PAIR;
         end else begin
            x2 = near_x[best];
            y2 = near_y[best];
            s2 = slope_mem[best];
            num = (s1 + s2) * (2 * lookahead - x1 - x2) + 512 * (y1 + y2);
            tyv = clip16((num + 512) >>> 10);
            ang = cordic_angle(2 * wheelbase_len * tyv, lookahead * lookahead + tyv * tyv);
            cmd.target_y = tyv[15:0];
            cmd.turn_rate = 16'(clip16((gain * ang + 2048) >>> 12));
            cmd.forward_speed = PAIR_SPEED;
         end
      end
      expected_cmds.insert(expected_cmds.size(), cmd);
      clear_scan();
   endfunction

   task automatic send_segment(input longint sx, input longint sy,
                               input longint ex, input longint ey,
                               input bit last);
      int gap;
      logic signed [15:0] sx16, sy16, ex16, ey16;
      sx16 = 16'(sx);
      sy16 = 16'(sy);
      ex16 = 16'(ex);
      ey16 = 16'(ey);
      gap = req_idling ? $urandom_range(0, 16) : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.start_x      <= sx16;
      req_if.start_y      <= sy16;
      req_if.end_x        <= ex16;
      req_if.end_y        <= ey16;
      req_if.last_segment <= last;
      do @(posedge clock); while (!req_if.ready);
      predict_steering(sx16, sy16, ex16, ey16, last);
      items_sent++;
   endtask

   task automatic stop_sending();
      req_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drain();
      while (expected_cmds.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input longint value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= PADDR_W'(idx) << 2;
      pwdata  <= value[31:0];
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_SLOPE_TOL: slope_tol     = value & 16'hFFFF;
         REG_MAX_SD:    max_sd        = value & 16'hFFFF;
         REG_MAX_PD:    max_pd        = value & 16'hFFFF;
         REG_LOOKAHEAD: lookahead     = value & 15'h7FFF;
         REG_WHEELBASE: wheelbase_len = value & 15'h7FFF;
         default:       gain          = value & 16'hFFFF;
      endcase
   endtask

   task automatic set_config(input longint tol, input longint sdiff, input longint pdist,
                             input longint la, input longint wb, input longint g);
      stop_sending();
      wait_drain();
      csr_write(REG_SLOPE_TOL, tol);
      csr_write(REG_MAX_SD, sdiff);
      csr_write(REG_MAX_PD, pdist);
      csr_write(REG_LOOKAHEAD, la);
      csr_write(REG_WHEELBASE, wb);
      csr_write(REG_GAIN, g);
      @(posedge clock);
   endtask

   // one scan: mostly wall segments on two sides with random content
   task automatic random_scan(input int nseg);
      longint half_w, base_slope, x0, len, y0, y1, side;
      int kind;
      half_w = $urandom_range(300, 4000);
      base_slope = longint'($urandom_range(0, 200)) - 100;
      for (int k = 0; k < nseg; k++) begin
         kind = $urandom_range(0, 99);
         side = (k % 2 == 0) ? 1 : -1;
         x0 = longint'($urandom_range(0, 9000)) - 1000;
         len = $urandom_range(200, 3000);
         if (kind < 70) begin
            y0 = side * half_w + base_slope * x0 / 256 + longint'($urandom_range(0, 100)) - 50;
            y1 = side * half_w + base_slope * (x0 + len) / 256
                 + longint'($urandom_range(0, 100)) - 50;
            if ($urandom_range(0, 1))
               send_segment(clip16(x0), clip16(y0), clip16(x0 + len), clip16(y1), k == nseg - 1);
            else
               send_segment(clip16(x0 + len), clip16(y1), clip16(x0), clip16(y0), k == nseg - 1);
         end else if (kind < 80) begin
            send_segment(-$urandom_range(1, 32768), $urandom, -$urandom_range(1, 32768),
                         $urandom, k == nseg - 1);
         end else if (kind < 85) begin
            y0 = $urandom;
            send_segment(clip16(x0), $urandom, clip16(x0), y0[15:0], k == nseg - 1);
         end else begin
            send_segment($urandom, $urandom, $urandom, $urandom, k == nseg - 1);
         end
      end
   endtask

   task automatic test_directed_cases();
      send_segment(100, 1000, 2000, 1000, 1);
      send_segment(-5, 200, -3, 400, 0);
      send_segment(100, 0, 100, 500, 1);
      send_segment(500, 1000, 3000, 1000, 0);
      send_segment(500, -1000, 3000, -1000, 1);
      send_segment(500, 1000, 3000, 1000, 0);
      send_segment(600, 1500, 3000, 1500, 1);
      send_segment(500, 1000, 3000, 1000, 0);
      send_segment(500, -1000, 3000, -1000, 0);
      send_segment(500, -1000, 2500, -1000, 1);
      send_segment(-32768, -32768, 32767, 32767, 0);
      send_segment(32767, 32767, -32768, -32768, 0);
      send_segment(0, -32768, 1, 32767, 0);
      send_segment(32767, 0, -32768, 1, 1);
      send_segment(0, 0, 0, 0, 0);
      send_segment(0, 0, 1000, 0, 0);
      send_segment(-1, 300, 0, 300, 1);
   endtask

   task automatic test_store_full();
      // more kept segments than the store holds and a segment count past saturation
      for (int k = 0; k < 130; k++)
         send_segment(k * 50 + 100, (k % 2) ? -1200 : 1200, k * 50 + 900,
                      (k % 2) ? -1200 : 1200, k == 129);
   endtask

   task automatic test_register_extremes();
      set_config(0, 0, 0, 1, 0, 0);
      random_scan(6);
      test_directed_cases();
      set_config(65535, 65535, 65535, 32767, 32767, 65535);
      random_scan(6);
      test_directed_cases();
      set_config(65535, 65535, 65535, 1, 32767, 65535);
      test_directed_cases();
      set_config(256, 128, 3072, 1024, 256, 256);
   endtask

   task automatic test_backpressure();
      req_idling = 0;
      rsp_hold = 400;
      for (int s = 0; s < 5; s++) random_scan(4);
      req_idling = 1;
   endtask

   task automatic test_drain_pause();
      random_scan(5);
      stop_sending();
      wait_drain();
      random_scan(5);
   endtask

   task automatic test_random_phases();
      int n;
      for (int phase = 0; phase < 8; phase++) begin
         if (phase > 0)
            set_config($urandom_range(64, 1024), $urandom_range(16, 512),
                       $urandom_range(1000, 20000), $urandom_range(1, 32767),
                       $urandom_range(0, 32767), $urandom_range(0, 65535));
         while (items_sent < (phase + 1) * 160 + 320) begin
            req_idling = $urandom_range(0, 3) != 0;
            rsp_idling = $urandom_range(0, 3) != 0;
            n = ($urandom_range(0, 39) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 12);
            random_scan(n);
         end
      end
   endtask

   // response side: random stalls, one long hold on request
   initial begin
      int stall;
      steer_cmd_type exp_cmd;
      rsp_if.ready <= 1'b0;
      @(negedge reset);
      forever begin
         stall = rsp_idling ? $urandom_range(0, 16) : 0;
         if (rsp_hold > 0) begin
            stall = rsp_hold;
            rsp_hold = 0;
         end
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         if (expected_cmds.size() == 0) begin
            $error("unexpected steering transaction");
            errors++;
         end else begin
            exp_cmd = expected_cmds.pop_front();
            if (rsp_if.status !== exp_cmd.status) begin
               $error("status: expected %0d, actual %0d", exp_cmd.status, rsp_if.status);
               errors++;
            end
            if (rsp_if.turn_rate !== exp_cmd.turn_rate) begin
               $error("turn_rate: expected %0d, actual %0d", exp_cmd.turn_rate,
                      rsp_if.turn_rate);
               errors++;
            end
            if (rsp_if.forward_speed !== exp_cmd.forward_speed) begin
               $error("forward_speed: expected %0d, actual %0d", exp_cmd.forward_speed,
                      rsp_if.forward_speed);
               errors++;
            end
            if (rsp_if.target_y !== exp_cmd.target_y) begin
               $error("target_y: expected %0d, actual %0d", exp_cmd.target_y,
                      rsp_if.target_y);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      clock = 1'b0;
      reset <= 1'b1;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      req_if.valid <= 1'b0;
      req_if.start_x <= '0;
      req_if.start_y <= '0;
      req_if.end_x <= '0;
      req_if.end_y <= '0;
      req_if.last_segment <= 1'b0;
      idle_cycles = 0;
      errors = 0;
      items_sent = 0;
      rsp_hold = 0;
      req_idling = 1;
      rsp_idling = 1;
      slope_tol = 256;
      max_sd = 128;
      max_pd = 3072;
      lookahead = 1024;
      wheelbase_len = 256;
      gain = 256;
      clear_scan();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_store_full();
      test_register_extremes();
      test_backpressure();
      test_drain_pause();
      test_random_phases();
      stop_sending();
      wait_drain();
      repeat (50) @(posedge clock);
      if (errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
